// ===== design/ake_pkg.sv =====
// Shared types, constants and S-box for the AES-128 key expansion core.
package ake_pkg;

  localparam int ROUND_COUNT    = 10;
  localparam int SCHED_WORDS    = 4 * (ROUND_COUNT + 1);
  localparam int KEY_FIFO_DEPTH = 2;
  localparam int KEY_PTR_W      = $clog2(KEY_FIFO_DEPTH);
  localparam int KEY_CNT_W      = $clog2(KEY_FIFO_DEPTH + 1);

  localparam logic [5:0] LAST_IDX = 6'(SCHED_WORDS - 1);
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } key_t;

  typedef struct packed {
    logic [5:0]  word_index;
    logic [31:0] round_key_word;
    logic        last_word;
  } word_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Rotate left by one byte, then substitute each byte.
  function automatic logic [31:0] rot_sub_word(input logic [31:0] w);
    logic [31:0] rot;
    rot = {w[23:0], w[31:24]};
    return {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
  endfunction

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

// ===== design/aes128_key_expansion_core.sv =====
// Top level of the AES-128 key expansion core: key queue, expander, result register.
//
// Push a 128-bit cipher key (key_high holds bytes 0 to 7, key_low bytes 8 to 15,
// lowest byte most significant) and pop the 44 words of its expanded schedule,
// word 0 first, each beat carrying the word, its index and a mark on word 43.
// The expander makes one word per cycle unless the pop side stalls it, with the
// S-box step done in the same cycle as the XOR. A key passes the key queue, the
// expander state and the result register before its first word can be popped,
// and when keys queue up the next one starts in the cycle that emits word 43 of
// the one before. Up to two keys wait in the front queue, so push keeps being
// taken while a schedule is running; a single result register parts the
// expander from the pop side and gives a word per cycle when pop is held high.
module aes128_key_expansion_core
  import ake_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  key_t  in_data,
  output logic  full,
  output logic  empty,
  input  logic  pop,
  output word_t out_data
);

  logic  key_valid, key_take;
  key_t  key_data;
  logic  word_valid, word_ready;
  word_t word_data;
  logic  out_valid_r, out_valid_nxt;
  word_t out_r;

  ake_key_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_data),
    .full      (full),
    .key_valid (key_valid),
    .key_data  (key_data),
    .key_take  (key_take)
  );

  ake_expand u_expand (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_valid  (key_valid),
    .key_data   (key_data),
    .key_take   (key_take),
    .word_valid (word_valid),
    .word_data  (word_data),
    .word_ready (word_ready)
  );

  // Advance the expander when the result register is free or being drained.
  assign word_ready = !out_valid_r || pop;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (word_valid && word_ready) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the word until popped; load a fresh one on each expander beat.
  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      out_r <= word_data;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

// ===== design/ake_key_fifo.sv =====
// Front end: short queue of accepted cipher keys.
module ake_key_fifo
  import ake_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  key_t push_data,
  output logic full,
  output logic key_valid,
  output key_t key_data,
  input  logic key_take
);

  key_t                 mem_r [KEY_FIFO_DEPTH];
  logic [KEY_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [KEY_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [KEY_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_wr, do_rd;

  assign full      = (cnt_r == KEY_CNT_W'(KEY_FIFO_DEPTH));
  assign key_valid = (cnt_r != '0);
  assign key_data  = mem_r[rd_ptr_r];
  assign do_wr     = push && !full;
  assign do_rd     = key_take && key_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == KEY_PTR_W'(KEY_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == KEY_PTR_W'(KEY_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= KEY_CNT_W'(KEY_FIFO_DEPTH))
    else $error("key queue count beyond depth");
`endif

endmodule

// ===== design/ake_expand.sv =====
// Back end: sequencer that produces one schedule word per cycle from a key while word_ready is high.
module ake_expand
  import ake_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  key_valid,
  input  key_t  key_data,
  output logic  key_take,
  output logic  word_valid,
  output word_t word_data,
  input  logic  word_ready
);

  logic        busy_r, busy_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [7:0]  rcon_r, rcon_nxt;
  logic [31:0] win_r [4];
  logic [31:0] win_nxt [4];
  logic        emit, last, head, start;
  logic [31:0] t_word, new_word;

  assign last  = (idx_r == LAST_IDX);
  assign head  = (idx_r < 6'd4);
  assign emit  = busy_r && word_ready;
  assign start = key_valid && (!busy_r || (emit && last));

  assign key_take = start;

  // Word four back sits in win_r[0], the previous word in win_r[3].
  always_comb begin
    t_word = win_r[3];
    if (idx_r[1:0] == 2'd0) begin
      t_word = rot_sub_word(win_r[3]) ^ {rcon_r, 24'h0};
    end
    new_word = head ? win_r[idx_r[1:0]] : (win_r[0] ^ t_word);
  end

  assign word_valid                = busy_r;
  assign word_data.word_index      = idx_r;
  assign word_data.round_key_word  = new_word;
  assign word_data.last_word       = last;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    rcon_nxt = rcon_r;
    win_nxt  = win_r;
    if (emit) begin
      idx_nxt = idx_r + 1'b1;
      if (!head) begin
        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = win_r[3];
        win_nxt[3] = new_word;
        if (idx_r[1:0] == 2'd0) begin
          rcon_nxt = xtime(rcon_r);
        end
      end
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (start) begin
      busy_nxt   = 1'b1;
      idx_nxt    = '0;
      rcon_nxt   = RCON_INIT;
      win_nxt[0] = key_data.key_high[63:32];
      win_nxt[1] = key_data.key_high[31:0];
      win_nxt[2] = key_data.key_low[63:32];
      win_nxt[3] = key_data.key_low[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      rcon_r <= RCON_INIT;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      rcon_r <= rcon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= LAST_IDX)
    else $error("schedule index past last word");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last) |=> (busy_r && idx_r == $past(idx_r) + 6'd1))
    else $error("schedule index did not advance");
  a_rcon_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rcon_r != 8'h00)
    else $error("round constant lost");
`endif

endmodule

// ===== sim/tb_aes128_key_expansion_core.sv =====
// Self-checking testbench for the AES-128 key expansion core, with its own schedule predictor.
module tb_aes128_key_expansion_core;
  import ake_pkg::*;

  localparam int          DIR_ROWS     = 13;
  localparam int          PHASES       = 4;
  localparam int          PHASE_KEYS   = 34;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          MAX_PRINTS   = 40;
  localparam logic [7:0]  FIELD_POLY   = 8'h1b;

  // One row of the directed table: the key, plus one schedule word whose value
  // can be read straight off the key or a published test vector.
  typedef struct packed {
    key_t        key;
    logic [5:0]  spot_idx;
    logic [31:0] spot_word;
  } key_row_t;

  logic  clk     = 1'b0;
  logic  rst_n   = 1'b0;
  logic  push    = 1'b0;
  key_t  in_data = '0;
  logic  full;
  logic  empty;
  logic  pop     = 1'b0;
  word_t out_data;

  logic [7:0]  sbox_lut [0:255];
  logic [31:0] sched_w  [0:SCHED_WORDS-1];
  word_t       pending_words [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fault_count    = 0;
  int unsigned words_checked  = 0;
  int unsigned keys_pushed    = 0;

  // Extremes first, then the two published key vectors, then single-bit and other fixed patterns.
  key_row_t dir_rows [0:DIR_ROWS-1] = '{
    {64'h0000000000000000, 64'h0000000000000000, 6'd4,  32'h62636363},
    {64'h0000000000000000, 64'h0000000000000000, 6'd43, 32'h6f8f188e},
    {64'hffffffffffffffff, 64'hffffffffffffffff, 6'd4,  32'he8e9e9e9},
    {64'hffffffffffffffff, 64'hffffffffffffffff, 6'd0,  32'hffffffff},
    {64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 6'd4,  32'ha0fafe17},
    {64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 6'd43, 32'hb6630ca6},
    {64'h0001020304050607, 64'h08090a0b0c0d0e0f, 6'd43, 32'h4d2b30c5},
    {64'h8000000000000000, 64'h0000000000000000, 6'd0,  32'h80000000},
    {64'h0000000000000000, 64'h0000000000000001, 6'd3,  32'h00000001},
    {64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 6'd2,  32'h5a5a5a5a},
    {64'hffffffffffffffff, 64'h0000000000000000, 6'd2,  32'h00000000},
    {64'h0000000000000000, 64'hffffffffffffffff, 6'd1,  32'h00000000},
    {64'h0123456789abcdef, 64'hfedcba9876543210, 6'd1,  32'h89abcdef}
  };

  aes128_key_expansion_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Multiply in GF(2^8) modulo the AES polynomial, shift and add.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY : 8'h00);
    end
    return acc;
  endfunction

  // Derive one S-box entry from first principles: field inverse (b^254, which
  // also sends zero to zero) followed by the affine map.
  function automatic logic [7:0] sbox_entry(input logic [7:0] b);
    logic [7:0] inv;
    inv = 8'h01;
    for (int i = 0; i < 254; i++) inv = gf_mul(inv, b);
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
               ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // Expand one key into sched_w and queue the 44 beats it must produce.
  task automatic expand_key_schedule(input key_t k);
    logic [31:0] t;
    logic [7:0]  rc;
    word_t       w;
    rc         = 8'h01;
    sched_w[0] = k.key_high[63:32];
    sched_w[1] = k.key_high[31:0];
    sched_w[2] = k.key_low[63:32];
    sched_w[3] = k.key_low[31:0];
    for (int i = 4; i < SCHED_WORDS; i++) begin
      t = sched_w[i-1];
      if (i % 4 == 0) begin
        // rotate left one byte, substitute, fold in the round constant
        t  = {sbox_lut[t[23:16]], sbox_lut[t[15:8]], sbox_lut[t[7:0]], sbox_lut[t[31:24]]}
             ^ {rc, 24'h000000};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? FIELD_POLY : 8'h00);
      end
      sched_w[i] = sched_w[i-4] ^ t;
    end
    for (int i = 0; i < SCHED_WORDS; i++) begin
      w.word_index     = 6'(i);
      w.round_key_word = sched_w[i];
      w.last_word      = (i == SCHED_WORDS - 1);
      pending_words.push_back(w);
    end
  endtask

  task automatic report_fault(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    fault_count++;
    if (fault_count <= MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // Compare one popped beat with the oldest pending word, field by field.
  task automatic check_beat(input word_t got);
    word_t want;
    if (pending_words.size() == 0) begin
      report_fault("beat with no word pending", 64'(got), 64'h0);
      return;
    end
    want = pending_words.pop_front();
    if (got.word_index !== want.word_index)
      report_fault("word_index", 64'(got.word_index), 64'(want.word_index));
    if (got.round_key_word !== want.round_key_word)
      report_fault($sformatf("round_key_word of word %0d", want.word_index),
                   64'(got.round_key_word), 64'(want.round_key_word));
    if (got.last_word !== want.last_word)
      report_fault($sformatf("last_word of word %0d", want.word_index),
                   64'(got.last_word), 64'(want.last_word));
    words_checked++;
  endtask

  // Offer one key, idling beforehand at the current sender rate; hold it until
  // a clock edge sees push high and full low, then predict its schedule.
  task automatic send_key(input key_t k);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= k;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    expand_key_schedule(k);
    keys_pushed++;
  endtask

  // Pop side: take a beat whenever the edge sees pop high and empty low, then
  // pick pop for the next cycle from the current stall rate.
  always @(posedge clk) begin
    if (rst_n && pop && empty === 1'b0) check_beat(out_data);
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    key_row_t    row;
    key_t        k;
    int unsigned idle_by_phase  [0:PHASES-1];
    int unsigned stall_by_phase [0:PHASES-1];

    // Phases: free running, sparse sender, stalling receiver, light gaps on both.
    idle_by_phase  = '{0, 82, 0, 20};
    stall_by_phase = '{0, 0, 82, 20};

    for (int b = 0; b < 256; b++) sbox_lut[b] = sbox_entry(8'(b));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: also confirm the predictor against the typed-in word.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      send_key(row.key);
      if (sched_w[row.spot_idx] !== row.spot_word)
        report_fault($sformatf("table row %0d word %0d", r, row.spot_idx),
                     64'(sched_w[row.spot_idx]), 64'(row.spot_word));
    end

    // Random keys; thin out about a quarter so long zero runs reach the S-box.
    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      for (int n = 0; n < PHASE_KEYS; n++) begin
        k.key_high = {$urandom, $urandom};
        k.key_low  = {$urandom, $urandom};
        if ($urandom_range(3) == 0) begin
          k.key_high &= {$urandom, $urandom};
          k.key_low  &= {$urandom, $urandom};
        end
        send_key(k);
      end
    end
    push <= 1'b0;

    // Drain, then hold a while longer so any stray beat is caught.
    recv_stall_pct = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Expanded %0d keys (%0d from the directed table) and checked %0d schedule words,",
             keys_pushed, DIR_ROWS, words_checked);
    $display("under free-running, sparse-sender, stalling-receiver and mixed pacing.");
    if (fault_count == 0)
      $display("aes128_key_expansion_core verification clean");
    else
      $display("aes128_key_expansion_core verification failed");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("aes128_key_expansion_core verification failed");
    $finish;
  end

endmodule
